/* rtl/hspt_pkg.sv */
// shared types, constants and lookup functions for the hall sector position tracker
package hspt_pkg;

    localparam int HISTORY_DEPTH_DEF = 5;

    localparam int CODE_W   = 3;
    localparam int SECTOR_W = 4;
    localparam int MODE_W   = 3;
    localparam int TIME_W   = 32;
    localparam int COUNT_W  = 32;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 112;

    // hall_mode register codes
    localparam logic [MODE_W-1:0] MODE_AUTO   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_TYPE120 = 3'd1;
    localparam logic [MODE_W-1:0] MODE_FLIP_A = 3'd2;
    localparam logic [MODE_W-1:0] MODE_FLIP_B = 3'd3;
    localparam logic [MODE_W-1:0] MODE_FLIP_C = 3'd4;

    localparam logic [CODE_W-1:0] CODE_ALL_LOW  = 3'b000;
    localparam logic [CODE_W-1:0] CODE_ALL_HIGH = 3'b111;

    // rotation count magnitude beyond which auto mode settles on 120 type
    localparam logic signed [COUNT_W-1:0] FORCE_ROT_LIMIT = 32'sd2;

    typedef enum logic [1:0] {
        DIR_UNKNOWN = 2'b00,
        DIR_CW      = 2'b01,
        DIR_CCW     = 2'b10
    } dir_t;

    typedef struct packed {
        logic [CODE_W-1:0]         type_mask;
        logic                      type_known;
        logic [COUNT_W-1:0]        transition_count;
        logic [TIME_W-1:0]         pulse_interval;
        logic signed [COUNT_W-1:0] rotation_count;
        logic                      direction_ccw;
        logic signed [SECTOR_W-1:0] sector;
    } result_t;

    typedef struct packed {
        logic              known;
        logic [CODE_W-1:0] mask;
    } hall_type_t;

    function automatic logic signed [SECTOR_W-1:0] sector_of_code(input logic [CODE_W-1:0] code);
        logic signed [SECTOR_W-1:0] s;
        case (code)
            3'd1:    s = 4'sd0;
            3'd2:    s = 4'sd4;
            3'd3:    s = 4'sd5;
            3'd4:    s = 4'sd2;
            3'd5:    s = 4'sd1;
            3'd6:    s = 4'sd3;
            default: s = -4'sd1;
        endcase
        return s;
    endfunction

    function automatic hall_type_t type_of_mode(input logic [MODE_W-1:0] mode);
        hall_type_t t;
        case (mode)
            MODE_TYPE120: t = '{known: 1'b1, mask: 3'b000};
            MODE_FLIP_A:  t = '{known: 1'b1, mask: 3'b100};
            MODE_FLIP_B:  t = '{known: 1'b1, mask: 3'b010};
            MODE_FLIP_C:  t = '{known: 1'b1, mask: 3'b001};
            default:      t = '{known: 1'b0, mask: 3'b000};
        endcase
        return t;
    endfunction

endpackage

/* rtl/hall_sector_position_tracker.sv */
// top level: hall sector decoder with direction, rotation, interval tracking and type detection
//
// Takes one hall sample per clock on the s_ stream (three line levels and a microsecond
// timestamp) and returns at most one result item per sample on the m_ stream, in the cycle
// after acceptance. A sample whose raw code equals the previous raw code is consumed and
// yields no result. All decoding, masking, direction, rotation and interval logic runs
// in the acceptance cycle between the tracking registers and the result register, so the
// sustained rate is one sample per clock; only a stalled, still-full result register holds
// off the input. In auto-detect mode the line-flip mask is inferred from an all-low or
// all-high code seen between two different codes, and 120-degree type is assumed once the
// rotation count exceeds two in either direction. Writing hall_mode reloads the type at
// once and keeps all other tracking state; write it only while the block is idle.
module hall_sector_position_tracker #(
    parameter int HISTORY_DEPTH = hspt_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // hall_mode
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [hspt_pkg::MODE_W-1:0]    cfg_data,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // hall_a, hall_b, hall_c, timestamp_us[31:0], zero pad
    input  logic [hspt_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // sector[3:0], direction_ccw, rotation_count[31:0], pulse_interval[31:0],
    // transition_count[31:0], type_known, type_mask[2:0], zero pad
    output logic [hspt_pkg::M_TDATA_W-1:0] m_tdata
);
    import hspt_pkg::*;

    localparam int RES_W = $bits(result_t);

    logic                        seen_reg;
    logic [CODE_W-1:0]           last_code_reg;
    logic [CODE_W-1:0]           hist_reg   [HISTORY_DEPTH];
    logic                        hvalid_reg [HISTORY_DEPTH];
    logic signed [SECTOR_W-1:0]  sector_reg;
    logic signed [COUNT_W-1:0]   rot_reg;
    dir_t                        prev_dir_reg;
    logic [TIME_W-1:0]           last_time_reg;
    logic [COUNT_W-1:0]          trans_reg;
    hall_type_t                  type_reg;
    result_t                     out_reg;
    logic                        out_valid_reg;

    logic                        s_fire;
    logic                        cfg_fire;
    logic                        changed;
    logic                        step;
    logic [CODE_W-1:0]           raw_code;
    logic [TIME_W-1:0]           ts;
    logic [CODE_W-1:0]           code;
    logic                        detect;
    logic [CODE_W-1:0]           det_mask;
    logic [CODE_W-1:0]           head_next;
    logic                        force120;
    hall_type_t                  type_next;
    logic signed [SECTOR_W-1:0]  new_sector;
    logic signed [SECTOR_W:0]    diff;
    dir_t                        dir_next;
    logic signed [COUNT_W-1:0]   rot_next;
    logic [TIME_W-1:0]           interval_next;
    logic [COUNT_W-1:0]          trans_next;
    result_t                     res_next;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign s_tready  = !out_valid_reg || m_tready;
    assign s_fire    = s_tvalid && s_tready;

    assign raw_code = {s_tdata[0], s_tdata[1], s_tdata[2]};
    assign ts       = s_tdata[TIME_W+CODE_W-1:CODE_W];
    assign changed  = !seen_reg || (raw_code != last_code_reg);
    assign step     = s_fire && changed;

    always_comb begin
        code      = type_reg.known ? (raw_code ^ type_reg.mask) : raw_code;
        // the new code lands at the head, so the old head becomes the second entry
        detect    = !type_reg.known && hvalid_reg[0]
                    && (hist_reg[0] == CODE_ALL_HIGH || hist_reg[0] == CODE_ALL_LOW)
                    && hvalid_reg[1] && (hist_reg[1] != code);
        det_mask  = CODE_ALL_HIGH ^ code ^ hist_reg[1];
        head_next = detect ? (code ^ det_mask) : code;
        force120  = !type_reg.known && (rot_reg > FORCE_ROT_LIMIT || rot_reg < -FORCE_ROT_LIMIT);

        type_next = type_reg;
        if (detect) begin
            type_next = '{known: 1'b1, mask: det_mask};
        end
        if (force120) begin
            type_next = '{known: 1'b1, mask: 3'b000};
        end

        new_sector = sector_of_code(code);
        diff       = {new_sector[SECTOR_W-1], new_sector} - {sector_reg[SECTOR_W-1], sector_reg};
        rot_next   = rot_reg;
        if (diff > 5'sd3) begin
            dir_next = DIR_CCW;
            rot_next = rot_reg - 32'sd1;
        end else if (diff < -5'sd3) begin
            dir_next = DIR_CW;
            rot_next = rot_reg + 32'sd1;
        end else begin
            // equal sectors count as counter-clockwise
            dir_next = (new_sector > sector_reg) ? DIR_CW : DIR_CCW;
        end

        interval_next = (dir_next == prev_dir_reg) ? (ts - last_time_reg) : '0;
        trans_next    = trans_reg + 32'd1;

        res_next.sector           = new_sector;
        res_next.direction_ccw    = (dir_next == DIR_CCW);
        res_next.rotation_count   = rot_next;
        res_next.pulse_interval   = interval_next;
        res_next.transition_count = trans_next;
        res_next.type_known       = type_next.known;
        res_next.type_mask        = type_next.mask;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg      <= 1'b0;
            sector_reg    <= '0;
            rot_reg       <= '0;
            prev_dir_reg  <= DIR_UNKNOWN;
            last_time_reg <= '0;
            trans_reg     <= '0;
            type_reg      <= '{known: 1'b0, mask: 3'b000};
            out_valid_reg <= 1'b0;
            for (int i = 0; i < HISTORY_DEPTH; i++) begin
                hvalid_reg[i] <= 1'b0;
            end
        end else begin
            if (m_tready && !step) begin
                out_valid_reg <= 1'b0;
            end
            if (s_fire) begin
                seen_reg <= 1'b1;
            end
            if (step) begin
                sector_reg    <= new_sector;
                rot_reg       <= rot_next;
                prev_dir_reg  <= dir_next;
                last_time_reg <= ts;
                trans_reg     <= trans_next;
                out_valid_reg <= 1'b1;
                if (!type_reg.known) begin
                    hvalid_reg[0] <= 1'b1;
                    for (int i = 1; i < HISTORY_DEPTH; i++) begin
                        hvalid_reg[i] <= hvalid_reg[i-1];
                    end
                end
            end
            if (cfg_fire) begin
                type_reg <= type_of_mode(cfg_data);
            end else if (step) begin
                type_reg <= type_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            last_code_reg <= raw_code;
        end
        if (step) begin
            out_reg <= res_next;
            if (!type_reg.known) begin
                hist_reg[0] <= head_next;
                for (int i = 1; i < HISTORY_DEPTH; i++) begin
                    hist_reg[i] <= hist_reg[i-1];
                end
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W-RES_W){1'b0}}, out_reg};

    a_count_tracks: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (out_reg.transition_count == trans_reg))
        else $error("pending result count differs from tracking count");

    a_dir_tracks: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (prev_dir_reg == (out_reg.direction_ccw ? DIR_CCW : DIR_CW)))
        else $error("pending result direction differs from stored direction");

    a_known_sticks: assert property (@(posedge aclk) disable iff (!aresetn)
        (type_reg.known && !cfg_fire) |=> type_reg.known)
        else $error("sensor type lost without a mode write");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !out_valid_reg |-> s_tready)
        else $error("input stalled while result register is empty");

endmodule
